// ===== hdl/mlv_pkg.sv =====
// Package for the metric line validator: byte classes, recogniser and
// line phase encodings, status codes and shared helper functions.
// No dependencies.
package mlv_pkg;

   localparam int unsigned MLV_QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_AT      = 8'h40;

   // bytes of "status" matched so far; MISS once the line can no longer match
   localparam logic [2:0] STATUS_LEN  = 3'd6;
   localparam logic [2:0] STATUS_MISS = 3'd7;

   typedef enum logic [2:0] {
      ST_VALID      = 3'd0,
      ST_NO_COLON   = 3'd1,
      ST_EMPTY_KEY  = 3'd2,
      ST_BAD_VALUE  = 3'd3,
      ST_NO_BAR     = 3'd4,
      ST_EMPTY_RATE = 3'd5,
      ST_BAD_RATE   = 3'd6,
      ST_BAD_TYPE   = 3'd7
   } line_status_type;

   typedef enum logic [3:0] {
      PH_KEY   = 4'b0001,
      PH_VALUE = 4'b0010,
      PH_TYPE  = 4'b0100,
      PH_RATE  = 4'b1000
   } phase_type;

   // number prefix recogniser (strtod-style prefix)
   typedef enum logic [8:0] {
      RC_START  = 9'b000000001,
      RC_SIGNED = 9'b000000010,
      RC_DOT    = 9'b000000100,
      RC_I      = 9'b000001000,
      RC_IN     = 9'b000010000,
      RC_N      = 9'b000100000,
      RC_NA     = 9'b001000000,
      RC_ACCEPT = 9'b010000000,
      RC_REJECT = 9'b100000000
   } rc_type;

   typedef struct packed {
      logic [7:0] data;
      logic       newline;
      logic       colon;
      logic       bar;
      logic       at;
      logic       digit;
      logic       dot;
      logic       space;
      logic       sign;
      logic       low_i;
      logic       low_n;
      logic       low_f;
      logic       low_a;
   } byte_class_type;

   function automatic byte_class_type classify(logic [7:0] b);
      byte_class_type c;
      logic [7:0]     l;
      l         = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      c.data    = b;
      c.newline = (b == CH_NEWLINE);
      c.colon   = (b == CH_COLON);
      c.bar     = (b == CH_BAR);
      c.at      = (b == CH_AT);
      c.digit   = (b >= "0" && b <= "9");
      c.dot     = (b == ".");
      c.space   = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
      c.sign    = (b == "+") || (b == "-");
      c.low_i   = (l == "i");
      c.low_n   = (l == "n");
      c.low_f   = (l == "f");
      c.low_a   = (l == "a");
      return c;
   endfunction

   function automatic rc_type recog_next(rc_type s, byte_class_type c);
      rc_type n;
      n = RC_REJECT;
      unique case (s)
         RC_START, RC_SIGNED: begin
            if (s == RC_START && c.space)     n = RC_START;
            else if (s == RC_START && c.sign) n = RC_SIGNED;
            else if (c.digit)                 n = RC_ACCEPT;
            else if (c.dot)                   n = RC_DOT;
            else if (c.low_i)                 n = RC_I;
            else if (c.low_n)                 n = RC_N;
         end
         RC_DOT:    n = c.digit ? RC_ACCEPT : RC_REJECT;
         RC_I:      n = c.low_n ? RC_IN : RC_REJECT;
         RC_IN:     n = c.low_f ? RC_ACCEPT : RC_REJECT;
         RC_N:      n = c.low_a ? RC_NA : RC_REJECT;
         RC_NA:     n = c.low_n ? RC_ACCEPT : RC_REJECT;
         RC_ACCEPT: n = RC_ACCEPT;
         RC_REJECT: n = RC_REJECT;
         default:   n = RC_REJECT;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] status_char(logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = "s";
         3'd1:    ch = "t";
         3'd2:    ch = "a";
         3'd3:    ch = "t";
         3'd4:    ch = "u";
         3'd5:    ch = "s";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== hdl/metric_line_validator.sv =====
// Metric line validator: checks key:value|type[@rate] lines, one byte an item.
// Throughput: one byte per cycle unless stalled; a held result stalls a newline.
// A taken newline goes through the queue, then into the registered result slot.
// req_stall rises only when the queue is full; that happens while a result is held.
// Reset (synchronous, active high) empties the queue, drops any pending result and
// returns the line state to the key phase. No clearing pass is needed.
module metric_line_validator
   import mlv_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = MLV_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_line_status,
   output logic       rsp_is_status_request
);

   byte_class_type front_class;
   byte_class_type head_class;
   logic           q_full;
   logic           q_not_empty;
   logic           q_pop;

   // front end: byte flags worked out before queueing so the checker stays shallow
   mlv_front u_front (
      .data_byte  (req_data_byte),
      .byte_class (front_class)
   );

   // queue decouples intake from the checker; it absorbs bytes while a
   // result waits in the output slot
   mlv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_item (front_class),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .head_item (head_class)
   );

   assign req_stall = q_full;

   // back end: line state, first-error priority, registered result
   mlv_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .item_ready            (q_not_empty),
      .item                  (head_class),
      .pop                   (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_line_status       (rsp_line_status),
      .rsp_is_status_request (rsp_is_status_request)
   );

endmodule

// ===== hdl/mlv_front.sv =====
// Front end: classifies each incoming byte into the flags the checker uses.
// Depends on mlv_pkg.
module mlv_front
   import mlv_pkg::*;
(
   input  logic [7:0]     data_byte,
   output byte_class_type byte_class
);

   assign byte_class = classify(data_byte);

endmodule

// ===== hdl/mlv_queue.sv =====
// Short queue of classified items between front end and checker.
// Depends on mlv_pkg.
module mlv_queue
   import mlv_pkg::*;
#(
   parameter int unsigned DEPTH = MLV_QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  byte_class_type push_item,
   output logic           full,
   output logic           not_empty,
   input  logic           pop,
   output byte_class_type head_item
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   byte_class_type   store_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ptr_ff] <= push_item;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

// ===== hdl/mlv_back.sv =====
// Back end: per-line checker state and registered result slot.
// Depends on mlv_pkg; fed from mlv_queue.
module mlv_back
   import mlv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_ready,
   input  byte_class_type item,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [2:0]     rsp_line_status,
   output logic           rsp_is_status_request
);

   phase_type  phase_ff,       phase_in;
   logic       key_seen_ff,    key_seen_in;
   rc_type     value_rc_ff,    value_rc_in;
   logic [7:0] type_c0_ff,     type_c0_in;
   logic [7:0] type_c1_ff,     type_c1_in;
   logic [1:0] type_count_ff,  type_count_in;
   rc_type     rate_rc_ff,     rate_rc_in;
   logic       rate_seen_ff,   rate_seen_in;
   logic [2:0] status_ff,      status_in;

   logic       rsp_valid_ff,   rsp_valid_in;
   logic [2:0] rsp_code_ff,    rsp_code_in;
   logic       rsp_stat_ff,    rsp_stat_in;

   logic            slot_free;
   logic            type_ok;
   line_status_type code;

   // a newline needs the result slot; other items always go through
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = item_ready && (!item.newline || slot_free);

   always_comb begin
      type_ok = 1'b0;
      if (type_count_ff == 2'd1)
         type_ok = (type_c0_ff == "c") || (type_c0_ff == "g") ||
                   (type_c0_ff == "h") || (type_c0_ff == "s");
      else if (type_count_ff == 2'd2)
         type_ok = (type_c0_ff == "m" && type_c1_ff == "s") ||
                   (type_c0_ff == "k" && type_c1_ff == "v");
   end

   // first failing check wins
   always_comb begin
      if (phase_ff == PH_KEY)                               code = ST_NO_COLON;
      else if (!key_seen_ff)                                code = ST_EMPTY_KEY;
      else if (value_rc_ff != RC_ACCEPT)                    code = ST_BAD_VALUE;
      else if (phase_ff == PH_VALUE)                        code = ST_NO_BAR;
      else if (phase_ff == PH_RATE && !rate_seen_ff)        code = ST_EMPTY_RATE;
      else if (phase_ff == PH_RATE && rate_rc_ff != RC_ACCEPT) code = ST_BAD_RATE;
      else if (!type_ok)                                    code = ST_BAD_TYPE;
      else                                                  code = ST_VALID;
   end

   always_comb begin
      phase_in      = phase_ff;
      key_seen_in   = key_seen_ff;
      value_rc_in   = value_rc_ff;
      type_c0_in    = type_c0_ff;
      type_c1_in    = type_c1_ff;
      type_count_in = type_count_ff;
      rate_rc_in    = rate_rc_ff;
      rate_seen_in  = rate_seen_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_code_in   = rsp_code_ff;
      rsp_stat_in   = rsp_stat_ff;

      if (pop && item.newline) begin
         rsp_valid_in  = 1'b1;
         rsp_stat_in   = (status_ff == STATUS_LEN);
         rsp_code_in   = (status_ff == STATUS_LEN) ? ST_VALID : code;
         phase_in      = PH_KEY;
         key_seen_in   = 1'b0;
         value_rc_in   = RC_START;
         type_count_in = 2'd0;
         rate_rc_in    = RC_START;
         rate_seen_in  = 1'b0;
         status_in     = 3'd0;
      end else if (pop) begin
         if (status_ff < STATUS_LEN && item.data == status_char(status_ff))
            status_in = status_ff + 1'b1;
         else
            status_in = STATUS_MISS;

         if (phase_ff == PH_KEY) begin
            if (item.colon) phase_in = PH_VALUE;
            else            key_seen_in = 1'b1;
         end else begin
            // value text runs on to the end of the line
            value_rc_in = recog_next(value_rc_ff, item);
            unique case (phase_ff)
               PH_VALUE: begin
                  if (item.bar) phase_in = PH_TYPE;
               end
               PH_TYPE: begin
                  if (item.at) begin
                     phase_in = PH_RATE;
                  end else begin
                     if (type_count_ff == 2'd0) type_c0_in = item.data;
                     if (type_count_ff == 2'd1) type_c1_in = item.data;
                     if (type_count_ff != 2'd3) type_count_in = type_count_ff + 1'b1;
                  end
               end
               PH_RATE: begin
                  rate_seen_in = 1'b1;
                  rate_rc_in   = recog_next(rate_rc_ff, item);
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_KEY;
         key_seen_ff   <= 1'b0;
         value_rc_ff   <= RC_START;
         type_count_ff <= 2'd0;
         rate_rc_ff    <= RC_START;
         rate_seen_ff  <= 1'b0;
         status_ff     <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         key_seen_ff   <= key_seen_in;
         value_rc_ff   <= value_rc_in;
         type_count_ff <= type_count_in;
         rate_rc_ff    <= rate_rc_in;
         rate_seen_ff  <= rate_seen_in;
         status_ff     <= status_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_c0_ff  <= type_c0_in;
      type_c1_ff  <= type_c1_in;
      rsp_code_ff <= rsp_code_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_line_status       = rsp_code_ff;
   assign rsp_is_status_request = rsp_stat_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(pop && item.newline))
      else $error("held result overwritten");

   a_newline_result: assert property (@(posedge clock) disable iff (reset)
      (pop && item.newline) |=> rsp_valid_ff)
      else $error("newline gave no result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stat_ff) |-> (rsp_code_ff == ST_VALID))
      else $error("status line with non-zero code");

endmodule

// ===== verif/tb_metric_line_validator.sv =====
// Testbench for metric_line_validator: feeds byte streams of metric lines and
// checks every line result against an in-bench predictor of the line rules.
// Depends on mlv_pkg (status, phase and recogniser enums) and the RTL top.
`timescale 1ns / 1ps

module tb_metric_line_validator;
   import mlv_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 8;       // spare edges to catch any stray result
   localparam int HOLD_CYCLES  = 60;      // long receiver hold-off for the pressure test

   localparam logic [8*6-1:0] STATUS_WORD = "status";

   typedef struct {
      line_status_type status;
      logic            is_status;
   } line_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_line_status;
   logic       rsp_is_status_request;

   metric_line_validator uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_data_byte         (req_data_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_line_status       (rsp_line_status),
      .rsp_is_status_request (rsp_is_status_request)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Line predictor: mirrors the per-byte line state and, on each newline,
   // queues the result the block should give for that line.
   // ---------------------------------------------------------------------
   line_result_type pending_results[$];

   phase_type  line_phase      = PH_KEY;
   logic       key_present     = 1'b0;
   rc_type     value_rc        = RC_START;
   logic       value_good      = 1'b0;
   logic [7:0] type_first      = 8'h00;
   logic [7:0] type_second     = 8'h00;
   logic [1:0] type_len        = 2'd0;  // saturates at 3: longer than any type
   rc_type     rate_rc         = RC_START;
   logic       rate_present    = 1'b0;
   logic [2:0] status_progress = 3'd0;

   int  error_count = 0;
   int  items_taken = 0;
   int  cycle_count = 0;
   bit  quiet_mode  = 1'b0;  // no sender gaps and no random receiver stalls while set
   int  rsp_hold_request = 0;

   // strtod-style number prefix: blanks, a sign, then digit, .digit, inf or nan
   function automatic rc_type number_step(rc_type s, logic [7:0] b);
      logic [7:0] l;
      logic       digit;
      logic       blank;
      l     = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      digit = (b >= "0" && b <= "9");
      blank = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
      case (s)
         RC_START, RC_SIGNED:
            if (s == RC_START && blank)                      number_step = RC_START;
            else if (s == RC_START && (b == "+" || b == "-")) number_step = RC_SIGNED;
            else if (digit)                                  number_step = RC_ACCEPT;
            else if (b == ".")                               number_step = RC_DOT;
            else if (l == "i")                               number_step = RC_I;
            else if (l == "n")                               number_step = RC_N;
            else                                             number_step = RC_REJECT;
         RC_DOT:    number_step = digit ? RC_ACCEPT : RC_REJECT;
         RC_I:      number_step = (l == "n") ? RC_IN : RC_REJECT;
         RC_IN:     number_step = (l == "f") ? RC_ACCEPT : RC_REJECT;
         RC_N:      number_step = (l == "a") ? RC_NA : RC_REJECT;
         RC_NA:     number_step = (l == "n") ? RC_ACCEPT : RC_REJECT;
         RC_ACCEPT: number_step = RC_ACCEPT;
         default:   number_step = RC_REJECT;
      endcase
   endfunction

   // first failing check wins, in the block's priority order
   function automatic line_status_type line_verdict();
      logic known_type;
      known_type = (type_len == 2'd1 && (type_first == "c" || type_first == "g" ||
                                         type_first == "h" || type_first == "s")) ||
                   (type_len == 2'd2 && ((type_first == "m" && type_second == "s") ||
                                         (type_first == "k" && type_second == "v")));
      if (line_phase == PH_KEY)                          return ST_NO_COLON;
      if (!key_present)                                  return ST_EMPTY_KEY;
      if (!value_good)                                   return ST_BAD_VALUE;
      if (line_phase == PH_VALUE)                        return ST_NO_BAR;
      if (line_phase == PH_RATE && !rate_present)        return ST_EMPTY_RATE;
      if (line_phase == PH_RATE && rate_rc != RC_ACCEPT) return ST_BAD_RATE;
      if (!known_type)                                   return ST_BAD_TYPE;
      return ST_VALID;
   endfunction

   task automatic track_byte(input logic [7:0] b);
      line_result_type r;
      if (b == CH_NEWLINE) begin
         r.is_status = (status_progress == STATUS_LEN);
         r.status    = r.is_status ? ST_VALID : line_verdict();
         pending_results.push_back(r);
         line_phase      = PH_KEY;
         key_present     = 1'b0;
         value_rc        = RC_START;
         value_good      = 1'b0;
         type_first      = 8'h00;
         type_second     = 8'h00;
         type_len        = 2'd0;
         rate_rc         = RC_START;
         rate_present    = 1'b0;
         status_progress = 3'd0;
      end else begin
         if (status_progress < STATUS_LEN &&
             b == STATUS_WORD[8 * (int'(STATUS_LEN) - 1 - int'(status_progress)) +: 8])
            status_progress = status_progress + 3'd1;
         else
            status_progress = STATUS_MISS;

         if (line_phase == PH_KEY) begin
            if (b == CH_COLON) line_phase = PH_VALUE;
            else key_present = 1'b1;
         end else begin
            // value text runs to the end of the line, through the type and rate
            value_rc = number_step(value_rc, b);
            if (value_rc == RC_ACCEPT) value_good = 1'b1;
            case (line_phase)
               PH_VALUE: begin
                  if (b == CH_BAR) line_phase = PH_TYPE;
               end
               PH_TYPE: begin
                  if (b == CH_AT) begin
                     line_phase = PH_RATE;
                  end else begin
                     if (type_len == 2'd0) type_first = b;
                     else if (type_len == 2'd1) type_second = b;
                     if (type_len != 2'd3) type_len = type_len + 2'd1;
                  end
               end
               default: begin
                  rate_present = 1'b1;
                  rate_rc      = number_step(rate_rc, b);
               end
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Idle lengths: mostly short, now and then long.
   // ---------------------------------------------------------------------
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // ---------------------------------------------------------------------
   // Sender: one item per call, predictor updated when the item is taken.
   // req_valid stays high between back-to-back items, so it is only lowered
   // in a step where nothing raises it again.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = (quiet_mode || $urandom_range(0, 9) < 6) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_byte(b);
      items_taken++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // letters go out in random case; inf and nan are case-blind
   task automatic send_mixed(input string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
         send_byte(c);
      end
   endtask

   // any byte but newline, all other values equally likely
   function automatic logic [7:0] any_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 254));
      if (b >= CH_NEWLINE) b = b + 8'd1;
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 4))
         0:       return 8'd9;
         1:       return 8'd11;
         2:       return 8'd12;
         3:       return 8'd13;
         default: return 8'd32;
      endcase
   endfunction

   function automatic string broken_number();
      case ($urandom_range(0, 12))
         0:       broken_number = "";
         1:       broken_number = ".";
         2:       broken_number = ".e";
         3:       broken_number = "i";
         4:       broken_number = "in";
         5:       broken_number = "inx";
         6:       broken_number = "n";
         7:       broken_number = "na";
         8:       broken_number = "nax";
         9:       broken_number = "x1";
         10:      broken_number = "+-1";
         11:      broken_number = "e5";
         default: broken_number = "-";
      endcase
   endfunction

   task automatic send_number();
      if ($urandom_range(0, 4) == 0) send_byte(blank_byte());
      if ($urandom_range(0, 2) == 0) send_byte(($urandom_range(0, 1) == 1) ? "+" : "-");
      case ($urandom_range(0, 10))
         0, 1, 2: send_text($sformatf("%0d", $urandom_range(0, 99999)));
         3:       send_text($sformatf(".%0d", $urandom_range(0, 99)));
         4:       send_text($sformatf("%0d.%0de-%0d", $urandom_range(0, 99),
                                      $urandom_range(0, 99), $urandom_range(0, 9)));
         5:       send_mixed("inf");
         6:       send_mixed("nan");
         7: begin
            // zero byte ends the number text before it is accepted
            send_byte(8'h00);
            send_text("1");
         end
         default: send_mixed(broken_number());
      endcase
   endtask

   task automatic send_type();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         case ($urandom_range(0, 5))
            0:       send_text("c");
            1:       send_text("ms");
            2:       send_text("kv");
            3:       send_text("g");
            4:       send_text("h");
            default: send_text("s");
         endcase
      end else if (pick == 8) begin
         case ($urandom_range(0, 9))
            0:       send_text("");
            1:       send_text("m");
            2:       send_text("k");
            3:       send_text("cc");
            4:       send_text("mss");
            5:       send_text("kvv");
            6:       send_text("C");
            7:       send_text("MS");
            8:       send_text("sm");
            default: send_text("x");
         endcase
      end else begin
         repeat ($urandom_range(0, 3)) send_byte(any_byte());
      end
   endtask

   // mostly well-formed key:value|type[@rate], with each part broken now and then
   task automatic send_metric_line();
      if ($urandom_range(0, 15) != 0) begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 7) == 0) send_byte(any_byte());
            else send_byte(8'($urandom_range(97, 122)));
         end
      end
      if ($urandom_range(0, 19) != 0) begin
         send_byte(CH_COLON);
         send_number();
         if ($urandom_range(0, 9) != 0) begin
            send_byte(CH_BAR);
            send_type();
            if ($urandom_range(0, 3) == 0) begin
               send_byte(CH_AT);
               if ($urandom_range(0, 5) != 0) send_number();
            end
         end
      end
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_byte(any_byte());
      send_byte(CH_NEWLINE);
   endtask

   task automatic send_status_like();
      case ($urandom_range(0, 6))
         0, 1:    send_text("status\n");
         2:       send_text("statu\n");
         3:       send_text("statuss\n");
         4:       send_text("Status\n");
         5:       send_text("sstatus\n");
         default: send_text("status:1|c\n");
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stall runs, plus a long hold-off when a test asks for
   // one. The hold is counted here, in the receiver's own process.
   // ---------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold_request > 0) begin
         stall_left       = rsp_hold_request - 1;
         rsp_hold_request = 0;
         rsp_stall       <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         stall_left = idle_length() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Result check: every item taken on the result side is matched with the
   // oldest predicted line result.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      line_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: expected no result, got line_status %0d is_status_request %0b",
                     $time, rsp_line_status, rsp_is_status_request);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_line_status !== want.status) begin
               $display("%0t: line_status expected %0d, got %0d",
                        $time, want.status, rsp_line_status);
               error_count++;
            end
            if (rsp_is_status_request !== want.is_status) begin
               $display("%0t: is_status_request expected %0b, got %0b",
                        $time, want.is_status, rsp_is_status_request);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding",
                  $time, pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // one line per status code, in priority order
   task automatic test_status_codes();
      send_text("\n");           // empty line: no colon
      send_text(":1|c\n");
      send_text("a:x|c\n");
      send_text("a:1\n");
      send_text("a:1|c@\n");
      send_text("a:1|c@x\n");
      send_text("a:1|q\n");
      send_text("status\n");
   endtask

   // accepted number prefixes and every valid type
   task automatic test_number_forms();
      send_text("k:-2|ms\n");
      send_text("k:.5|kv\n");
      send_text("k:\t+Inf|g\n");
      send_text("k:nAn|h\n");
      send_text("k:1|s@ 0.1\n");
      send_text("k:1|c@-.5e\n");
   endtask

   task automatic test_special_cases();
      // zero byte inside the value, then as the only type byte
      send_text("k:");
      send_byte(8'h00);
      send_text("1|c\n");
      send_text("k:1|");
      send_byte(8'h00);
      send_byte(CH_NEWLINE);
      // byte extremes in the key
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text(":1|g\n");
      // later separators are plain bytes of their part
      send_text("a:1:2|c|d@x@y\n");
      send_text("a:1|ms@1@2\n");
      // near misses of the status word
      send_text("statuss\n");
      send_text("stat\n");
   endtask

   task automatic test_random_lines(input int count);
      int start;
      int pick;
      start = items_taken;
      while (items_taken - start < count) begin
         pick = $urandom_range(0, 19);
         if (pick < 16) begin
            send_metric_line();
         end else if (pick < 18) begin
            send_status_like();
         end else begin
            // noise, ended by a newline so it still yields a line result
            repeat ($urandom_range(0, 8)) send_byte(any_byte());
            send_byte(CH_NEWLINE);
         end
      end
   endtask

   // receiver holds off while the sender keeps pushing short lines, so the
   // internal queue fills and req_stall has to rise
   task automatic test_backpressure();
      quiet_mode       = 1'b1;
      rsp_hold_request = HOLD_CYCLES;
      repeat (10) send_byte(CH_NEWLINE);
      repeat (6) send_text("a:1|c\n");
      quiet_mode = 1'b0;
   endtask

   // a stretch with no gaps on either side
   task automatic test_no_idle_stretch();
      quiet_mode = 1'b1;
      test_random_lines(100);
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_status_codes();
      test_number_forms();
      test_special_cases();
      test_random_lines(220);
      test_backpressure();
      test_no_idle_stretch();
      test_random_lines(220);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
